// ===== src/blur3_pkg.sv =====
// ----------------------------------------------------------------------------
// blur3_pkg: shared types, constants and helpers of the 3x3 binomial blur
// Widths of the pixel, row and column fields, register codes, the line
// buffer entry layout and the [1,2,1] quarter-sum helper.
// ----------------------------------------------------------------------------
package blur3_pkg;

   localparam int PIX_W        = 8;
   localparam int COL_W        = 9;
   localparam int ROW_W        = 10;
   localparam int WIDTH_CFG_W  = 10;
   localparam int HEIGHT_CFG_W = 11;
   localparam int MAX_WIDTH    = 512;
   localparam int MAX_HEIGHT   = 1024;
   localparam int SUM_W        = PIX_W + 2;

   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = HEIGHT_CFG_W;

   localparam int RSP_FIELD_W  = PIX_W + ROW_W + COL_W;
   localparam int RSP_DATA_W   = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELD_W;

   localparam int MAX_RESULTS  = 4;
   localparam int RES_CNT_W    = 3;

   localparam int BANK_DEPTH   = MAX_WIDTH / 2;
   localparam int BANK_ADDR_W  = $clog2(BANK_DEPTH);

   localparam logic [COL_W-1:0] WIDTH_LAST_RESET  = COL_W'(319);
   localparam logic [ROW_W-1:0] HEIGHT_LAST_RESET = ROW_W'(199);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // One line buffer column: the horizontal results of rows r-2 and r-1.
   typedef struct packed {
      logic [PIX_W-1:0] upper;
      logic [PIX_W-1:0] mid;
   } line_entry_type;

   localparam int ENTRY_W = $bits(line_entry_type);

   typedef struct packed {
      logic                   en;
      logic [BANK_ADDR_W-1:0] addr;
      line_entry_type         data;
   } line_wr_type;

   // Horizontal stage word handed from the front end to the vertical pass.
   typedef struct packed {
      logic [PIX_W-1:0] h1;
      logic [PIX_W-1:0] h2;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             has_h1;
      logic             last_col;
      logic             last_row;
   } hstage_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } result_type;

   // (a + 2b + c) >> 2, exact; (3e + n) >> 2 is the same with a = b = e.
   function automatic logic [PIX_W-1:0] blend121(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b,
                                                 input logic [PIX_W-1:0] c);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(a) + {1'b0, b, 1'b0} + SUM_W'(c);
      return sum[SUM_W-1:2];
   endfunction

endpackage

// ===== src/blur3_line_ram.sv =====
// ----------------------------------------------------------------------------
// blur3_line_ram: simple dual-port line buffer memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module blur3_line_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== src/blur3_hpass.sv =====
// ----------------------------------------------------------------------------
// blur3_hpass: input register, position counters and horizontal pass
// Accepts pixels, keeps the two previous raw pixels of the row, forms the
// horizontal [1,2,1] values and issues the line buffer reads.
// ----------------------------------------------------------------------------
module blur3_hpass import blur3_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [COL_W-1:0]       width_last,
   input  logic [ROW_W-1:0]       height_last,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIX_W-1:0]       req_tdata,
   output logic                   hs_valid,
   input  logic                   hs_ready,
   output hstage_type             hs_data,
   output logic                   rd_en,
   output logic [BANK_ADDR_W-1:0] rd_addr_even,
   output logic [BANK_ADDR_W-1:0] rd_addr_odd
);

   logic [COL_W-1:0] col_count_ff, col_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic [PIX_W-1:0] back_one_ff, back_one_in;
   logic [PIX_W-1:0] back_two_ff, back_two_in;
   logic             hs_valid_ff, hs_valid_in;
   hstage_type       hs_ff, hs_in;

   logic             accept;
   logic [COL_W-1:0] col;
   logic [ROW_W-1:0] row;
   logic             last_col;
   logic             last_row;
   logic [COL_W-2:0] col_half;

   // A counter left beyond a smaller frame size counts as the last position.
   assign col      = (col_count_ff > width_last) ? width_last : col_count_ff;
   assign row      = (row_count_ff > height_last) ? height_last : row_count_ff;
   assign last_col = (col == width_last);
   assign last_row = (row == height_last);

   assign req_tready = !hs_valid_ff || hs_ready;
   assign accept     = req_tvalid && req_tready;

   // Columns col-1 and col sit in opposite banks.
   assign col_half     = col[COL_W-1:1];
   assign rd_en        = accept;
   assign rd_addr_even = col_half;
   assign rd_addr_odd  = col[0] ? col_half : col_half - BANK_ADDR_W'(1);

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      back_one_in  = back_one_ff;
      back_two_in  = back_two_ff;
      hs_valid_in  = hs_valid_ff && !hs_ready;
      hs_in        = hs_ff;
      if (accept) begin
         hs_valid_in     = 1'b1;
         hs_in.h1        = (col == COL_W'(1)) ? blend121(back_one_ff, back_one_ff, req_tdata)
                                              : blend121(back_two_ff, back_one_ff, req_tdata);
         hs_in.h2        = blend121(back_one_ff, req_tdata, req_tdata);
         hs_in.col       = col;
         hs_in.row       = row;
         hs_in.has_h1    = (col != '0);
         hs_in.last_col  = last_col;
         hs_in.last_row  = last_row;
         back_two_in     = back_one_ff;
         back_one_in     = req_tdata;
         if (last_col) begin
            col_count_in = '0;
            row_count_in = last_row ? '0 : row + ROW_W'(1);
         end else begin
            col_count_in = col + COL_W'(1);
            row_count_in = row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         back_one_ff  <= '0;
         back_two_ff  <= '0;
         hs_valid_ff  <= 1'b0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         back_one_ff  <= back_one_in;
         back_two_ff  <= back_two_in;
         hs_valid_ff  <= hs_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hs_ff <= hs_in;
   end

   assign hs_valid = hs_valid_ff;
   assign hs_data  = hs_ff;

   a_hs_hold: assert property (@(posedge clock) disable iff (reset)
      hs_valid_ff && !hs_ready |=> hs_valid_ff && $stable(hs_ff))
      else $error("horizontal stage word changed while the vertical pass stalled");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && last_col && last_row |=> col_count_ff == '0 && row_count_ff == '0)
      else $error("position counters did not wrap after the final pixel of a frame");

endmodule

// ===== src/blur3_vpass.sv =====
// ----------------------------------------------------------------------------
// blur3_vpass: vertical pass, line buffer update and result queue
// Combines the horizontal values with the two stored rows, writes the line
// buffers back and sends up to four results one word per rsp_tready cycle.
// ----------------------------------------------------------------------------
module blur3_vpass import blur3_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  hs_valid,
   output logic                  hs_ready,
   input  hstage_type            hs_data,
   input  line_entry_type        rd_data_even,
   input  line_entry_type        rd_data_odd,
   output line_wr_type           wr_even,
   output line_wr_type           wr_odd,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   result_type           res_ff [MAX_RESULTS];
   result_type           res_in [MAX_RESULTS];
   logic [RES_CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic                 res_frame_ff, res_frame_in;

   result_type           slot [MAX_RESULTS];
   logic [RES_CNT_W-1:0] res_num;
   line_entry_type       e1, e2;
   logic                 odd;
   logic                 row_zero, row_one;
   logic                 has1, has2;
   logic [ROW_W-1:0]     row_above;
   logic [COL_W-1:0]     col_left;
   logic [BANK_ADDR_W-1:0] half;
   logic                 res_free, hs_adv, out_accept;
   result_type           a1, b1, a2, b2;

   assign odd       = hs_data.col[0];
   assign half      = hs_data.col[COL_W-1:1];
   assign e1        = odd ? rd_data_even : rd_data_odd;
   assign e2        = odd ? rd_data_odd : rd_data_even;
   assign row_zero  = (hs_data.row == '0);
   assign row_one   = (hs_data.row == ROW_W'(1));
   assign row_above = hs_data.row - ROW_W'(1);
   assign col_left  = hs_data.col - COL_W'(1);
   assign has1      = hs_data.has_h1 && !row_zero;
   assign has2      = hs_data.last_col && !row_zero;

   // The top row uses its own edge rule; the bottom row adds a second result.
   always_comb begin
      a1.pixel = row_one ? blend121(e1.mid, e1.mid, hs_data.h1)
                         : blend121(e1.upper, e1.mid, hs_data.h1);
      a1.row   = row_above;
      a1.col   = col_left;
      b1.pixel = blend121(e1.mid, hs_data.h1, hs_data.h1);
      b1.row   = hs_data.row;
      b1.col   = col_left;
      a2.pixel = row_one ? blend121(e2.mid, e2.mid, hs_data.h2)
                         : blend121(e2.upper, e2.mid, hs_data.h2);
      a2.row   = row_above;
      a2.col   = hs_data.col;
      b2.pixel = blend121(e2.mid, hs_data.h2, hs_data.h2);
      b2.row   = hs_data.row;
      b2.col   = hs_data.col;
      if (hs_data.last_row) begin
         slot[0] = a1;
         slot[1] = b1;
         slot[2] = a2;
         slot[3] = b2;
         res_num = (has1 ? RES_CNT_W'(2) : '0) + (has2 ? RES_CNT_W'(2) : '0);
      end else begin
         slot[0] = a1;
         slot[1] = a2;
         slot[2] = b1;
         slot[3] = b2;
         res_num = RES_CNT_W'(has1) + RES_CNT_W'(has2);
      end
   end

   assign out_accept = rsp_tvalid && rsp_tready;
   assign res_free   = (res_cnt_ff == '0) || (res_cnt_ff == RES_CNT_W'(1) && rsp_tready);
   assign hs_ready   = res_free;
   assign hs_adv     = hs_valid && res_free;

   // Line buffers shift down one row at every column a horizontal value
   // reaches, the top row included.
   always_comb begin
      wr_even.en        = hs_adv && (odd ? hs_data.has_h1 : hs_data.last_col);
      wr_even.addr      = half;
      wr_even.data.upper = odd ? e1.mid : e2.mid;
      wr_even.data.mid   = odd ? hs_data.h1 : hs_data.h2;
      wr_odd.en         = hs_adv && (odd ? hs_data.last_col : hs_data.has_h1);
      wr_odd.addr       = odd ? half : half - BANK_ADDR_W'(1);
      wr_odd.data.upper = odd ? e2.mid : e1.mid;
      wr_odd.data.mid   = odd ? hs_data.h2 : hs_data.h1;
   end

   always_comb begin
      res_in       = res_ff;
      res_cnt_in   = res_cnt_ff;
      res_frame_in = res_frame_ff;
      if (out_accept) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            res_in[i] = res_ff[i + 1];
         end
         res_cnt_in = res_cnt_ff - RES_CNT_W'(1);
      end
      if (hs_adv) begin
         res_in       = slot;
         res_cnt_in   = res_num;
         res_frame_in = hs_data.last_col && hs_data.last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_cnt_ff <= '0;
      end else begin
         res_cnt_ff <= res_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff       <= res_in;
      res_frame_ff <= res_frame_in;
   end

   assign rsp_tvalid = (res_cnt_ff != '0);
   assign rsp_tdata  = {RSP_PAD_W'(0), res_ff[0].col, res_ff[0].row, res_ff[0].pixel};
   assign rsp_tlast  = (res_cnt_ff == RES_CNT_W'(1));
   assign rsp_tuser  = res_frame_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      res_cnt_ff <= RES_CNT_W'(MAX_RESULTS))
      else $error("result queue count beyond its depth");

   a_mid_rows: assert property (@(posedge clock) disable iff (reset)
      hs_adv && !hs_data.last_row |-> res_num <= RES_CNT_W'(2))
      else $error("more than two results for a pixel above the bottom row");

   a_final_pixel: assert property (@(posedge clock) disable iff (reset)
      hs_adv && hs_data.last_col && hs_data.last_row && !row_zero
      |-> res_num == RES_CNT_W'(MAX_RESULTS))
      else $error("final pixel of a frame did not yield four results");

endmodule

// ===== src/binomial_3x3_blur_stream.sv =====
// ----------------------------------------------------------------------------
// binomial_3x3_blur_stream: streaming separable 3x3 binomial blur
// Top level: configuration registers, horizontal front end, two banked line
// buffers and the vertical pass with its result queue.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one word per clock, and each row is first
// smoothed horizontally with [1,2,1]/4, then vertically through two line
// buffers; at an image edge the missing neighbour is replaced by the edge
// pixel, giving (3*edge+neighbour)/4. A result word carries the blurred
// pixel with its row and column. Output lags input by one column and one
// row: the first row yields nothing, a pixel in the middle rows yields the
// result one row up and one column left, and the last pixel of a row also
// yields its own column. In the bottom row every horizontal value yields
// two results, so the last pixel of the frame yields four; tlast marks the
// last result word of each input word and tuser marks every result of the
// frame's final pixel. Throughput is one pixel per clock while each pixel
// yields at most one result and rsp_tready is high; the output port moves
// one result per clock while rsp_tready is high, so in the bottom row and at
// each row end the input is held until the extra results have gone out. An
// accepted pixel passes the horizontal stage register, with the line buffer
// read, then the vertical pass into the result queue register. The line
// buffers are split into even and odd column banks so that the two columns
// touched at a row end each get their own read and write port. Line buffer
// contents are not cleared at reset; a full frame written with unchanged
// sizes always overwrites what is read. Frame width and height are to be
// written through the csr port between frames; the block does not enforce
// it. Width (csr_data[9:0]) saturates into 2..512, height into 2..1024.
// ----------------------------------------------------------------------------
module binomial_3x3_blur_stream import blur3_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // configuration write channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   // pixel input stream
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [PIX_W-1:0]        req_tdata,   // [7:0] pixel_in
   // result stream
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // [7:0] pixel_out, [17:8] out_row,
                                                // [26:18] out_col, rest zero
   output logic                    rsp_tlast,   // run_end
   output logic                    rsp_tuser    // frame_done
);

   // Sizes are held as their last index, already saturated.
   logic [COL_W-1:0] width_last_ff, width_last_in;
   logic [ROW_W-1:0] height_last_ff, height_last_in;

   logic [WIDTH_CFG_W-1:0]  width_val, width_m1;
   logic [HEIGHT_CFG_W-1:0] height_val, height_m1;
   logic                    csr_accept;

   hstage_type             hs_data;
   logic                   hs_valid, hs_ready;
   logic                   rd_en;
   logic [BANK_ADDR_W-1:0] rd_addr_even, rd_addr_odd;
   line_entry_type         rd_data_even, rd_data_odd;
   line_wr_type            wr_even, wr_odd;

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   assign width_val  = csr_data[WIDTH_CFG_W-1:0];
   assign height_val = csr_data[HEIGHT_CFG_W-1:0];
   assign width_m1   = width_val - WIDTH_CFG_W'(1);
   assign height_m1  = height_val - HEIGHT_CFG_W'(1);

   always_comb begin
      width_last_in  = width_last_ff;
      height_last_in = height_last_ff;
      if (csr_accept) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH: begin
               if (width_val < WIDTH_CFG_W'(2)) begin
                  width_last_in = COL_W'(1);
               end else if (width_val > WIDTH_CFG_W'(MAX_WIDTH)) begin
                  width_last_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  width_last_in = width_m1[COL_W-1:0];
               end
            end
            CSR_FRAME_HEIGHT: begin
               if (height_val < HEIGHT_CFG_W'(2)) begin
                  height_last_in = ROW_W'(1);
               end else if (height_val > HEIGHT_CFG_W'(MAX_HEIGHT)) begin
                  height_last_in = ROW_W'(MAX_HEIGHT - 1);
               end else begin
                  height_last_in = height_m1[ROW_W-1:0];
               end
            end
            default: begin
               width_last_in  = width_last_ff;
               height_last_in = height_last_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= WIDTH_LAST_RESET;
         height_last_ff <= HEIGHT_LAST_RESET;
      end else begin
         width_last_ff  <= width_last_in;
         height_last_ff <= height_last_in;
      end
   end

   blur3_hpass u_hpass (
      .clock        (clock),
      .reset        (reset),
      .width_last   (width_last_ff),
      .height_last  (height_last_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .hs_valid     (hs_valid),
      .hs_ready     (hs_ready),
      .hs_data      (hs_data),
      .rd_en        (rd_en),
      .rd_addr_even (rd_addr_even),
      .rd_addr_odd  (rd_addr_odd)
   );

   // Even columns of both stored rows.
   blur3_line_ram #(
      .DEPTH (BANK_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_ram_even (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_even),
      .rd_data (rd_data_even),
      .wr_en   (wr_even.en),
      .wr_addr (wr_even.addr),
      .wr_data (wr_even.data)
   );

   // Odd columns of both stored rows.
   blur3_line_ram #(
      .DEPTH (BANK_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_ram_odd (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_odd),
      .rd_data (rd_data_odd),
      .wr_en   (wr_odd.en),
      .wr_addr (wr_odd.addr),
      .wr_data (wr_odd.data)
   );

   blur3_vpass u_vpass (
      .clock        (clock),
      .reset        (reset),
      .hs_valid     (hs_valid),
      .hs_ready     (hs_ready),
      .hs_data      (hs_data),
      .rd_data_even (rd_data_even),
      .rd_data_odd  (rd_data_odd),
      .wr_even      (wr_even),
      .wr_odd       (wr_odd),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser)
   );

endmodule
